[sv/irc_ltd_pkg.sv]
`timescale 1ns / 1ps

package irc_ltd_pkg;

  // default limits
  localparam int MAX_PARAMS_DEF      = 16;
  localparam int MAX_COMMAND_LEN_DEF = 16;

  // all table commands are four letters long
  localparam int CMD_NAME_LEN = 4;
  localparam int CMD_COUNT    = 3;

  localparam logic [7:0] CHAR_COLON = 8'h3A;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_LOW_A = 8'h61;
  localparam logic [7:0] CHAR_LOW_Z = 8'h7A;
  localparam logic [7:0] CASE_GAP   = 8'h20;

  // input item kinds
  localparam logic MODE_CHAR = 1'b0;
  localparam logic MODE_EOL  = 1'b1;

  // line parser phases
  typedef enum logic [2:0] {
    PH_START  = 3'd0,
    PH_PREFIX = 3'd1,
    PH_PRECMD = 3'd2,
    PH_CMD    = 3'd3,
    PH_GAP    = 3'd4,
    PH_MIDDLE = 3'd5,
    PH_TRAIL  = 3'd6,
    PH_DROP   = 3'd7
  } phase_t;

  // byte tags
  localparam logic [2:0] KIND_SEP    = 3'd0;
  localparam logic [2:0] KIND_PREFIX = 3'd1;
  localparam logic [2:0] KIND_CMD    = 3'd2;
  localparam logic [2:0] KIND_MIDDLE = 3'd3;
  localparam logic [2:0] KIND_TRAIL  = 3'd4;

  // verdicts
  localparam logic [1:0] ST_DISPATCH  = 2'd0;
  localparam logic [1:0] ST_UNKNOWN   = 2'd1;
  localparam logic [1:0] ST_NOT_REG   = 2'd2;
  localparam logic [1:0] ST_FEW_PARAM = 2'd3;

  // command ids
  localparam logic [1:0] ID_NICK = 2'd0;
  localparam logic [1:0] ID_USER = 2'd1;
  localparam logic [1:0] ID_QUIT = 2'd2;
  localparam logic [1:0] ID_NONE = 2'd3;

  // letter of a command name at a given position
  function automatic logic [7:0] cmd_letter(input logic [1:0] id, input logic [1:0] pos);
    logic [31:0] name;
    case (id)
      ID_NICK: name = "NICK";
      ID_USER: name = "USER";
      ID_QUIT: name = "QUIT";
      default: name = 32'h0;
    endcase
    case (pos)
      2'd0:    cmd_letter = name[31:24];
      2'd1:    cmd_letter = name[23:16];
      2'd2:    cmd_letter = name[15:8];
      default: cmd_letter = name[7:0];
    endcase
  endfunction

  function automatic logic cmd_needs_reg(input logic [1:0] id);
    cmd_needs_reg = (id == ID_QUIT);
  endfunction

  function automatic logic [2:0] cmd_min_params(input logic [1:0] id);
    case (id)
      ID_USER: cmd_min_params = 3'd4;
      default: cmd_min_params = 3'd0;
    endcase
  endfunction

endpackage

[sv/irc_line_tokenizer_dispatch_top.sv]
`timescale 1ns / 1ps

// IRC command line tokenizer and dispatcher.
// Input channel (in_valid/in_ready) carries one item per line byte with
// mode = 0, then one end-of-line item with mode = 1 (client_registered is
// sampled there). Output channel (out_valid/out_ready) returns exactly one
// item per input item: the echoed byte with its tag and parameter index,
// or, for end of line, line_done = 1 with status, command_id and
// param_count.
// An accepted item is written into the output register at the edge that
// accepts it. One item is taken per cycle unless the receiver stalls; the
// phase machine, the three command comparators and the parameter counter
// all settle between the parser state and the output register.
// in_ready is high whenever the output register is empty or is being
// taken in the same cycle, so a stalled receiver holds its item and
// pushes back on the input after one item is buffered.
// Reset empties the output register and puts the parser at line start.
module irc_line_tokenizer_dispatch_top
  import irc_ltd_pkg::*;
#(
  parameter int MAX_PARAMS      = MAX_PARAMS_DEF,
  parameter int MAX_COMMAND_LEN = MAX_COMMAND_LEN_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       mode,
  input  logic [7:0] char_in,
  input  logic       client_registered,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] char_out,
  output logic [2:0] token_kind,
  output logic [3:0] param_index,
  output logic       line_done,
  output logic [1:0] status,
  output logic [1:0] command_id,
  output logic [4:0] param_count
);

  localparam int PW  = $clog2(MAX_PARAMS + 1);
  localparam int CLW = $clog2(MAX_COMMAND_LEN + 1);
  localparam int XW  = PW + 4;

  // parser state
  phase_t                 phase, phase_next;
  logic [PW-1:0]          params_seen, params_seen_next;
  logic [CLW-1:0]         command_length, command_length_next;
  logic [CMD_COUNT-1:0]   match_vector, match_vector_next;
  logic                   command_seen, command_seen_next;

  // result fields
  logic [7:0] char_next;
  logic [2:0] kind_next;
  logic [3:0] pidx_next;
  logic [1:0] status_next;
  logic [1:0] id_next;
  logic [4:0] count_next;

  logic       in_fire;
  logic [7:0] upper_c;
  logic       is_space;
  logic       is_colon;
  logic       do_cmd;
  logic [CMD_COUNT-1:0] cmd_hit;
  logic [XW-1:0] seen_ext;
  logic [XW-1:0] seen_minus1;

  assign in_ready = !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;

  assign is_space = (char_in == CHAR_SPACE);
  assign is_colon = (char_in == CHAR_COLON);
  assign upper_c  = (char_in >= CHAR_LOW_A && char_in <= CHAR_LOW_Z) ?
                    char_in - CASE_GAP : char_in;

  assign seen_ext    = XW'(params_seen);
  assign seen_minus1 = seen_ext - XW'(1);

  // per-entry command letter compare at the current position
  always_comb begin
    for (int i = 0; i < CMD_COUNT; i++) begin
      cmd_hit[i] = (command_length < CLW'(CMD_NAME_LEN)) &&
                   (cmd_letter(2'(i), command_length[1:0]) == upper_c);
    end
  end

  // phase machine and verdict
  always_comb begin
    phase_next          = phase;
    params_seen_next    = params_seen;
    command_length_next = command_length;
    match_vector_next   = match_vector;
    command_seen_next   = command_seen;
    char_next           = char_in;
    kind_next           = KIND_SEP;
    pidx_next           = 4'd0;
    status_next         = ST_DISPATCH;
    id_next             = ID_NICK;
    count_next          = 5'd0;
    do_cmd              = 1'b0;

    if (mode == MODE_EOL) begin
      char_next   = 8'd0;
      status_next = ST_UNKNOWN;
      id_next     = ID_NONE;
      if (command_seen && command_length == CLW'(CMD_NAME_LEN)) begin
        if (match_vector[0])      id_next = ID_NICK;
        else if (match_vector[1]) id_next = ID_USER;
        else if (match_vector[2]) id_next = ID_QUIT;
      end
      if (id_next != ID_NONE) begin
        if (cmd_needs_reg(id_next) && !client_registered) begin
          status_next = ST_NOT_REG;
        end else if (seen_ext < XW'(cmd_min_params(id_next))) begin
          status_next = ST_FEW_PARAM;
        end else begin
          status_next = ST_DISPATCH;
        end
      end
      count_next          = seen_ext[4:0];
      phase_next          = PH_START;
      params_seen_next    = '0;
      command_length_next = '0;
      match_vector_next   = '1;
      command_seen_next   = 1'b0;
    end else begin
      case (phase)
        PH_START: begin
          if (is_colon) begin
            phase_next = PH_PREFIX;
            kind_next  = KIND_PREFIX;
          end else if (is_space) begin
            phase_next = PH_PRECMD;
          end else begin
            phase_next = PH_CMD;
            do_cmd     = 1'b1;
          end
        end
        PH_PREFIX: begin
          if (is_space) phase_next = PH_PRECMD;
          else          kind_next  = KIND_PREFIX;
        end
        PH_PRECMD: begin
          if (!is_space) begin
            phase_next = PH_CMD;
            do_cmd     = 1'b1;
          end
        end
        PH_CMD: begin
          if (is_space) phase_next = PH_GAP;
          else          do_cmd     = 1'b1;
        end
        PH_GAP: begin
          if (!is_space) begin
            if (seen_ext >= XW'(MAX_PARAMS)) begin
              phase_next = PH_DROP;
            end else begin
              params_seen_next = params_seen + PW'(1);
              if (is_colon) begin
                phase_next = PH_TRAIL;
              end else begin
                phase_next = PH_MIDDLE;
                kind_next  = KIND_MIDDLE;
                pidx_next  = seen_ext[3:0];
              end
            end
          end
        end
        PH_MIDDLE: begin
          if (is_space) begin
            phase_next = PH_GAP;
          end else begin
            kind_next = KIND_MIDDLE;
            pidx_next = seen_minus1[3:0];
          end
        end
        PH_TRAIL: begin
          kind_next = KIND_TRAIL;
          pidx_next = seen_minus1[3:0];
        end
        default: begin
          phase_next = PH_DROP;
        end
      endcase

      // command letter: narrow the match set, count the length
      if (do_cmd) begin
        kind_next         = KIND_CMD;
        match_vector_next = match_vector & cmd_hit;
        command_seen_next = 1'b1;
        if (command_length < CLW'(MAX_COMMAND_LEN)) begin
          command_length_next = command_length + CLW'(1);
        end
      end
    end
  end

  // parser state register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_START;
      params_seen    <= '0;
      command_length <= '0;
      match_vector   <= '1;
      command_seen   <= 1'b0;
    end else if (in_fire) begin
      phase          <= phase_next;
      params_seen    <= params_seen_next;
      command_length <= command_length_next;
      match_vector   <= match_vector_next;
      command_seen   <= command_seen_next;
    end
  end

  // output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      char_out    <= char_next;
      token_kind  <= kind_next;
      param_index <= pidx_next;
      line_done   <= (mode == MODE_EOL);
      status      <= status_next;
      command_id  <= id_next;
      param_count <= count_next;
    end
  end

  // end of line always returns the parser to line start
  a_eol_clears: assert property (@(posedge clk) disable iff (rst)
    in_fire && mode == MODE_EOL |=>
      phase == PH_START && params_seen == '0 && command_seen == 1'b0)
    else $error("parser state not cleared after end of line");

  // parameter count never passes the limit
  a_params_bound: assert property (@(posedge clk) disable iff (rst)
    XW'(params_seen) <= XW'(MAX_PARAMS))
    else $error("params_seen beyond limit");

  // end-of-line items carry no byte and no tag
  a_eol_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && line_done |->
      char_out == 8'd0 && token_kind == KIND_SEP && param_index == 4'd0)
    else $error("end-of-line item carries byte fields");

  // dispatch only for a matched command
  a_dispatch_id: assert property (@(posedge clk) disable iff (rst)
    out_valid && line_done && status == ST_DISPATCH |-> command_id != ID_NONE)
    else $error("dispatch without a matched command");

  // a held item is not overwritten while the receiver stalls
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("input accepted while output is stalled");

endmodule

[sim/tb_irc_line_tokenizer_dispatch_top.sv]
`timescale 1ns / 1ps

module tb_irc_line_tokenizer_dispatch_top;
  import irc_ltd_pkg::*;

  // one input item as offered on the input channel
  typedef struct packed {
    logic       mode;
    logic [7:0] ch;
    logic       is_reg;
  } line_item_t;

  // one tagged byte or one end-of-line verdict
  typedef struct packed {
    logic [7:0] ch;
    logic [2:0] kind;
    logic [3:0] pidx;
    logic       done;
    logic [1:0] st;
    logic [1:0] id;
    logic [4:0] cnt;
  } token_tag_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic       mode = MODE_CHAR;
  logic [7:0] char_in = 8'h00;
  logic       client_registered = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] char_out;
  logic [2:0] token_kind;
  logic [3:0] param_index;
  logic       line_done;
  logic [1:0] status;
  logic [1:0] command_id;
  logic [4:0] param_count;

  irc_line_tokenizer_dispatch_top dut (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .mode              (mode),
    .char_in           (char_in),
    .client_registered (client_registered),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .char_out          (char_out),
    .token_kind        (token_kind),
    .param_index       (param_index),
    .line_done         (line_done),
    .status            (status),
    .command_id        (command_id),
    .param_count       (param_count)
  );

  always #4 clk = ~clk;

  // stimulus and scoreboard storage
  line_item_t line_bytes_q[$];
  token_tag_t tokens_due[$];
  line_item_t drv_item;
  token_tag_t want;
  token_tag_t got;
  bit         in_taken = 1'b0;
  int         snd_idle_pct = 0;
  int         rcv_idle_pct = 0;
  bit         hold_start = 1'b0;
  int         hold_left = 0;
  int         mismatch_count = 0;
  int         items_queued = 0;
  int         results_checked = 0;
  int         lines_checked = 0;
  int         verdict_seen[4];

  // parser copy kept by the scoreboard
  phase_t     ln_phase;
  int         params_seen;
  int         cmd_len;
  logic [2:0] cmd_match;
  bit         cmd_seen;

  function automatic logic [7:0] table_letter(input logic [1:0] idx, input int pos);
    logic [31:0] w;
    case (idx)
      ID_NICK: w = "NICK";
      ID_USER: w = "USER";
      default: w = "QUIT";
    endcase
    return w[31 - 8 * pos -: 8];
  endfunction

  function automatic void clear_line();
    ln_phase = PH_START;
    params_seen = 0;
    cmd_len = 0;
    cmd_match = 3'b111;
    cmd_seen = 1'b0;
  endfunction

  // fold case and narrow the set of commands still matching
  function automatic void take_cmd_byte(input logic [7:0] c);
    logic [7:0] u;
    u = (c >= CHAR_LOW_A && c <= CHAR_LOW_Z) ? c - CASE_GAP : c;
    for (int i = 0; i < CMD_COUNT; i++) begin
      if (cmd_len >= CMD_NAME_LEN || table_letter(i[1:0], cmd_len % CMD_NAME_LEN) != u)
        cmd_match[i] = 1'b0;
    end
    if (cmd_len < MAX_COMMAND_LEN_DEF) cmd_len++;
    cmd_seen = 1'b1;
  endfunction

  // next parameter opens; false when the line is already full
  function automatic bit open_param();
    if (params_seen >= MAX_PARAMS_DEF) begin
      ln_phase = PH_DROP;
      return 1'b0;
    end
    params_seen++;
    return 1'b1;
  endfunction

  // tag one accepted item and advance the parser copy
  function automatic token_tag_t parse_item(input logic m, input logic [7:0] c,
                                            input logic is_reg);
    token_tag_t t;
    t = '0;
    if (m == MODE_EOL) begin
      t.done = 1'b1;
      t.st = ST_UNKNOWN;
      t.id = ID_NONE;
      if (cmd_seen && cmd_len == CMD_NAME_LEN) begin
        if (cmd_match[0]) t.id = ID_NICK;
        else if (cmd_match[1]) t.id = ID_USER;
        else if (cmd_match[2]) t.id = ID_QUIT;
      end
      if (t.id != ID_NONE) begin
        if (t.id == ID_QUIT && !is_reg) t.st = ST_NOT_REG;
        else if (t.id == ID_USER && params_seen < 4) t.st = ST_FEW_PARAM;
        else t.st = ST_DISPATCH;
      end
      t.cnt = params_seen[4:0];
      clear_line();
      return t;
    end
    t.ch = c;
    t.kind = KIND_SEP;
    case (ln_phase)
      PH_START: begin
        if (c == CHAR_COLON) begin
          ln_phase = PH_PREFIX;
          t.kind = KIND_PREFIX;
        end else if (c == CHAR_SPACE) begin
          ln_phase = PH_PRECMD;
        end else begin
          ln_phase = PH_CMD;
          take_cmd_byte(c);
          t.kind = KIND_CMD;
        end
      end
      PH_PREFIX: begin
        if (c == CHAR_SPACE) ln_phase = PH_PRECMD;
        else t.kind = KIND_PREFIX;
      end
      PH_PRECMD: begin
        if (c != CHAR_SPACE) begin
          ln_phase = PH_CMD;
          take_cmd_byte(c);
          t.kind = KIND_CMD;
        end
      end
      PH_CMD: begin
        if (c == CHAR_SPACE) begin
          ln_phase = PH_GAP;
        end else begin
          take_cmd_byte(c);
          t.kind = KIND_CMD;
        end
      end
      PH_GAP: begin
        if (c != CHAR_SPACE && open_param()) begin
          if (c == CHAR_COLON) begin
            ln_phase = PH_TRAIL;
          end else begin
            ln_phase = PH_MIDDLE;
            t.kind = KIND_MIDDLE;
            t.pidx = 4'(params_seen - 1);
          end
        end
      end
      PH_MIDDLE: begin
        if (c == CHAR_SPACE) begin
          ln_phase = PH_GAP;
        end else begin
          t.kind = KIND_MIDDLE;
          t.pidx = 4'(params_seen - 1);
        end
      end
      PH_TRAIL: begin
        t.kind = KIND_TRAIL;
        t.pidx = 4'(params_seen - 1);
      end
      default: ln_phase = PH_DROP;
    endcase
    return t;
  endfunction

  task automatic report_mismatch(input string what, input int got_v, input int want_v);
    $display("%0t ns: %s: got %0d, want %0d", $time, what, got_v, want_v);
    mismatch_count++;
  endtask

  // stimulus builders
  task automatic push_byte(input logic [7:0] c);
    line_item_t it;
    it.mode = MODE_CHAR;
    it.ch = c;
    it.is_reg = 1'($urandom_range(1));
    line_bytes_q.push_back(it);
    items_queued++;
  endtask

  task automatic push_eol(input logic is_reg);
    line_item_t it;
    it.mode = MODE_EOL;
    it.ch = 8'($urandom_range(255));
    it.is_reg = is_reg;
    line_bytes_q.push_back(it);
    items_queued++;
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i]);
  endtask

  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(255));
    while (b == CHAR_SPACE || b == CHAR_COLON);
    return b;
  endfunction

  function automatic logic [7:0] non_space_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(255));
    while (b == CHAR_SPACE);
    return b;
  endfunction

  task automatic push_spaces(input int lo, input int hi);
    int n;
    n = $urandom_range(hi, lo);
    repeat (n) push_byte(CHAR_SPACE);
  endtask

  // mostly well-formed lines with random content, some pure noise
  task automatic queue_random_line();
    string near_letters;
    logic [7:0] c;
    int style, k, n, np;
    near_letters = "NICKUSERQT";
    style = $urandom_range(99);
    if (style < 12) begin
      n = $urandom_range(24);
      repeat (n) begin
        k = $urandom_range(99);
        if (k < 30) push_byte(CHAR_SPACE);
        else if (k < 45) push_byte(CHAR_COLON);
        else push_byte(8'($urandom_range(255)));
      end
    end else begin
      // optional prefix
      if ($urandom_range(3) == 0) begin
        push_byte(CHAR_COLON);
        n = $urandom_range(5);
        repeat (n) push_byte(plain_byte());
        push_spaces(1, 2);
      end else if ($urandom_range(4) == 0) begin
        push_spaces(1, 2);
      end
      // command word
      k = $urandom_range(9);
      if (k < 6) begin
        n = $urandom_range(2);
        for (int i = 0; i < CMD_NAME_LEN; i++) begin
          c = table_letter(n[1:0], i);
          if ($urandom_range(1)) c = c + CASE_GAP;
          push_byte(c);
        end
      end else if (k < 8) begin
        n = $urandom_range(6, 1);
        repeat (n) begin
          c = near_letters[$urandom_range(near_letters.len() - 1)];
          if ($urandom_range(1)) c = c + CASE_GAP;
          push_byte(c);
        end
      end else if (k == 8) begin
        n = $urandom_range(20, 5);
        repeat (n) push_byte(plain_byte());
      end
      // parameters, the last one sometimes trailing
      np = ($urandom_range(9) == 0) ? $urandom_range(20, 14) : $urandom_range(6);
      for (int j = 0; j < np; j++) begin
        push_spaces(1, 3);
        if (j == np - 1 && $urandom_range(9) < 4) begin
          push_byte(CHAR_COLON);
          n = $urandom_range(6);
          repeat (n) push_byte(($urandom_range(3) == 0) ? CHAR_SPACE : 8'($urandom_range(255)));
        end else begin
          push_byte(plain_byte());
          n = $urandom_range(3);
          repeat (n) push_byte(non_space_byte());
        end
      end
      if ($urandom_range(9) == 0) push_spaces(1, 2);
    end
    push_eol(1'($urandom_range(1)));
  endtask

  // wait until the sender has nothing left and every result is back
  task automatic drain_all();
    while (line_bytes_q.size() != 0 || in_valid || tokens_due.size() != 0)
      @(negedge clk);
  endtask

  // input driver
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_taken) begin
      // item still on offer
    end else if (line_bytes_q.size() != 0 && $urandom_range(99) >= snd_idle_pct) begin
      drv_item = line_bytes_q.pop_front();
      in_valid <= 1'b1;
      mode <= drv_item.mode;
      char_in <= drv_item.ch;
      client_registered <= drv_item.is_reg;
    end else begin
      in_valid <= 1'b0;
    end
  end

  // receiver with random stalls and one long hold-off
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_start || hold_left != 0) begin
      if (hold_start) begin
        hold_start = 1'b0;
        hold_left = 64;
      end
      hold_left = hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  // monitor: check results, then predict newly accepted items
  always @(posedge clk) begin
    if (rst) begin
      in_taken = 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (tokens_due.size() == 0) begin
          report_mismatch("result with nothing due, char_out", char_out, 0);
        end else begin
          want = tokens_due.pop_front();
          results_checked++;
          if (char_out !== want.ch) report_mismatch("char_out", char_out, want.ch);
          if (token_kind !== want.kind) report_mismatch("token_kind", token_kind, want.kind);
          if (param_index !== want.pidx)
            report_mismatch("param_index", param_index, want.pidx);
          if (line_done !== want.done) report_mismatch("line_done", line_done, want.done);
          if (status !== want.st) report_mismatch("status", status, want.st);
          if (command_id !== want.id) report_mismatch("command_id", command_id, want.id);
          if (param_count !== want.cnt)
            report_mismatch("param_count", param_count, want.cnt);
          if (want.done) begin
            lines_checked++;
            verdict_seen[want.st]++;
          end
        end
      end
      in_taken = in_valid && in_ready;
      if (in_taken) begin
        got = parse_item(mode, char_in, client_registered);
        tokens_due.push_back(got);
      end
    end
  end

  // run limit
  initial begin
    #5ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    clear_line();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // sender idles often, receiver stalls most of the time
    snd_idle_pct = 38;
    rcv_idle_pct = 80;
    // case folding, dispatch
    push_text("nIcK");
    push_eol(1'b1);
    // prefix, leading spaces, empty trailing part, unregistered quit
    push_text(":p  QUIT :");
    push_eol(1'b0);
    // prefix with no command
    push_text(":x");
    push_eol(1'b1);
    // byte extremes as a middle parameter, user short of parameters
    push_text("USER ");
    push_byte(8'hFF);
    push_byte(8'h00);
    push_eol(1'b1);
    while (items_queued < 700) queue_random_line();
    drain_all();

    // the other way round
    snd_idle_pct = 80;
    rcv_idle_pct = 38;
    while (items_queued < 1350) queue_random_line();
    drain_all();

    // full rate, with one long receiver hold while the sender keeps offering
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    while (items_queued < 2000) queue_random_line();
    @(posedge clk);
    hold_start = 1'b1;
    drain_all();

    repeat (10) @(posedge clk);
    $display("covered %0d input items in %0d lines, %0d results checked",
             items_queued, lines_checked, results_checked);
    $display("verdicts: dispatch %0d, unknown %0d, not registered %0d, few params %0d",
             verdict_seen[ST_DISPATCH], verdict_seen[ST_UNKNOWN],
             verdict_seen[ST_NOT_REG], verdict_seen[ST_FEW_PARAM]);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
